// ----- design/ttc_pkg.sv -----
// ----------------------------------------------------------------------------
// ttc_pkg
// Types, constants and the arctangent table shared by the compass blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package ttc_pkg;

  // sample averages in Q16.8, offset-corrected magnetometer values one bit wider
  typedef logic signed [24:0] avg_t;
  typedef logic signed [25:0] magc_t;

  // binary angle, 2^32 is a full turn
  typedef logic signed [33:0] ang_t;

  typedef struct packed {
    avg_t  ax;
    avg_t  ay;
    avg_t  az;
    magc_t mx;
    magc_t my;
    magc_t mz;
  } ttc_item_t;

  typedef struct packed {
    logic [8:0]         gain;
    logic signed [15:0] off_x;
    logic signed [15:0] off_y;
    logic signed [15:0] off_z;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic vec;
  } cor_ctl_t;

  typedef enum logic [1:0] {
    REG_GAIN  = 2'd0,
    REG_OFF_X = 2'd1,
    REG_OFF_Y = 2'd2,
    REG_OFF_Z = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    COR_IDLE,
    COR_NORM,
    COR_ITER,
    COR_DONE
  } cor_state_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_ATAN_ROLL,
    BK_SC_ROLL,
    BK_MUL_A,
    BK_MUL_B,
    BK_ATAN_PITCH,
    BK_SC_PITCH,
    BK_ATAN_HEAD,
    BK_OUT
  } bk_state_t;

  typedef enum logic [3:0] {
    OP_DEN0 = 4'd0,
    OP_DEN1 = 4'd1,
    OP_BOT0 = 4'd2,
    OP_BOT1 = 4'd3,
    OP_T1   = 4'd4,
    OP_T2   = 4'd5,
    OP_T3   = 4'd6,
    OP_RL0  = 4'd7,
    OP_RL1  = 4'd8,
    OP_PT0  = 4'd9,
    OP_PT1  = 4'd10,
    OP_HD0  = 4'd11,
    OP_HD1  = 4'd12
  } mul_op_t;

  localparam logic [8:0]         GAIN_RESET    = 9'd51;
  localparam logic [8:0]         GAIN_ONE      = 9'd256;
  localparam ang_t               ANG_HALF      = 34'sd2147483648;
  localparam ang_t               ANG_QUARTER   = 34'sd1073741824;
  localparam logic signed [35:0] COR_K         = 36'sh026DD3B6A;
  localparam logic signed [35:0] NORM_LIMIT    = 36'sd536870912;
  localparam logic signed [35:0] NORM_COARSE   = 36'sd33554432;
  localparam logic signed [31:0] ANGLE_TO_OUT  = 32'sd1510060666;
  localparam logic signed [15:0] FULL_TURN_OUT = 16'sd23040;
  localparam int                 TAB_IDX_W     = 5;

  function automatic ang_t atan_entry(input logic [TAB_IDX_W-1:0] idx);
    ang_t r;
    case (idx)
      5'd0:    r = 34'sh020000000;
      5'd1:    r = 34'sh012E4051E;
      5'd2:    r = 34'sh009FB385B;
      5'd3:    r = 34'sh0051111D4;
      5'd4:    r = 34'sh0028B0D43;
      5'd5:    r = 34'sh00145D7E1;
      5'd6:    r = 34'sh000A2F61E;
      5'd7:    r = 34'sh000517C55;
      5'd8:    r = 34'sh00028BE53;
      5'd9:    r = 34'sh000145F2F;
      5'd10:   r = 34'sh0000A2F98;
      5'd11:   r = 34'sh0000517CC;
      5'd12:   r = 34'sh000028BE6;
      5'd13:   r = 34'sh0000145F3;
      5'd14:   r = 34'sh00000A2FA;
      5'd15:   r = 34'sh00000517D;
      5'd16:   r = 34'sh0000028BE;
      5'd17:   r = 34'sh00000145F;
      5'd18:   r = 34'sh000000A30;
      5'd19:   r = 34'sh000000518;
      5'd20:   r = 34'sh00000028C;
      5'd21:   r = 34'sh000000146;
      5'd22:   r = 34'sh0000000A3;
      5'd23:   r = 34'sh000000051;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- design/ttc_if.sv -----
// ----------------------------------------------------------------------------
// ttc_if
// Valid/ready channels for the raw sensor set and the angle result.
// ----------------------------------------------------------------------------
`default_nettype none

interface ttc_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic signed [15:0] mag_x;
  logic signed [15:0] mag_y;
  logic signed [15:0] mag_z;

  modport source (output valid, accel_x, accel_y, accel_z, mag_x, mag_y, mag_z,
                  input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, mag_x, mag_y, mag_z,
                output ready);
endinterface

interface ttc_result_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] roll_angle;
  logic signed [14:0] pitch_angle;
  logic [14:0]        heading_angle;

  modport source (output valid, roll_angle, pitch_angle, heading_angle, input ready);
  modport sink (input valid, roll_angle, pitch_angle, heading_angle, output ready);
endinterface

`default_nettype wire

// ----- design/ttc_front.sv -----
// ----------------------------------------------------------------------------
// ttc_front
// Takes raw sensor sets, runs the exponential averages and hard-iron
// correction, and pushes the smoothed set into the work queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ttc_front (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire ttc_pkg::cfg_t cfg,
  ttc_sample_if.sink        sample,
  input  wire logic         q_full,
  output logic              push,
  output ttc_pkg::ttc_item_t push_item
);

  logic               held;
  logic signed [15:0] s_ax, s_ay, s_az, s_mx, s_my, s_mz;
  ttc_pkg::avg_t      acc_avg [3];
  ttc_pkg::avg_t      mag_avg [3];
  ttc_pkg::avg_t      acc_new [3];
  ttc_pkg::avg_t      mag_new [3];
  logic [8:0]         beta;

  function automatic ttc_pkg::avg_t smooth(input ttc_pkg::avg_t avg,
                                           input logic signed [15:0] s,
                                           input logic [8:0] b);
    logic signed [25:0] diff;
    logic signed [35:0] prod;
    logic signed [35:0] rnd;
    logic signed [35:0] res;
    diff = 26'(avg) - $signed({{2{s[15]}}, s, 8'b0});
    prod = 36'(diff) * 36'($signed({1'b0, b}));
    rnd  = (prod + 36'sd128) >>> 8;
    res  = 36'(avg) - rnd;
    return res[24:0];
  endfunction

  function automatic ttc_pkg::magc_t correct(input ttc_pkg::avg_t avg,
                                             input logic signed [15:0] off);
    return 26'(avg) - $signed({{2{off[15]}}, off, 8'b0});
  endfunction

  assign beta         = (cfg.gain > ttc_pkg::GAIN_ONE) ? ttc_pkg::GAIN_ONE : cfg.gain;
  assign push         = held && !q_full;
  assign sample.ready = !held || !q_full;

  always_comb begin
    acc_new[0] = smooth(acc_avg[0], s_ax, beta);
    acc_new[1] = smooth(acc_avg[1], s_ay, beta);
    acc_new[2] = smooth(acc_avg[2], s_az, beta);
    mag_new[0] = smooth(mag_avg[0], s_mx, beta);
    mag_new[1] = smooth(mag_avg[1], s_my, beta);
    mag_new[2] = smooth(mag_avg[2], s_mz, beta);
    push_item.ax = acc_new[0];
    push_item.ay = acc_new[1];
    push_item.az = acc_new[2];
    push_item.mx = correct(mag_new[0], cfg.off_x);
    push_item.my = correct(mag_new[1], cfg.off_y);
    push_item.mz = correct(mag_new[2], cfg.off_z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (sample.valid && sample.ready) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      s_ax <= sample.accel_x;
      s_ay <= sample.accel_y;
      s_az <= sample.accel_z;
      s_mx <= sample.mag_x;
      s_my <= sample.mag_y;
      s_mz <= sample.mag_z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        acc_avg[k] <= '0;
        mag_avg[k] <= '0;
      end
    end else if (push) begin
      for (int k = 0; k < 3; k++) begin
        acc_avg[k] <= acc_new[k];
        mag_avg[k] <= mag_new[k];
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/ttc_queue.sv -----
// ----------------------------------------------------------------------------
// ttc_queue
// Two-entry queue of smoothed sensor sets between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module ttc_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire ttc_pkg::ttc_item_t push_item,
  output logic                    full,
  input  wire logic               pop,
  output logic                    empty,
  output ttc_pkg::ttc_item_t      head_item
);

  ttc_pkg::ttc_item_t entries [2];
  logic               wr_ptr;
  logic               rd_ptr;
  logic [1:0]         count;

  assign full      = (count == 2'd2);
  assign empty     = (count == 2'd0);
  assign head_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ----- design/ttc_cordic.sv -----
// ----------------------------------------------------------------------------
// ttc_cordic
// Iterative CORDIC, one micro-rotation per cycle. Vectoring mode gives
// atan2(y, x) after a normalizing pre-shift; rotation mode gives cos and sin.
// ----------------------------------------------------------------------------
`default_nettype none

module ttc_cordic #(
  parameter int STAGES = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ttc_pkg::cor_ctl_t  ctl,
  input  wire logic signed [27:0] in_y,
  input  wire logic signed [27:0] in_x,
  input  wire ttc_pkg::ang_t      in_z,
  output logic                    done,
  output logic signed [31:0]      res_x,
  output logic signed [31:0]      res_y,
  output ttc_pkg::ang_t           res_z
);

  localparam int IW = (STAGES > 1) ? $clog2(STAGES) : 1;
  localparam logic [IW-1:0] LAST = IW'(STAGES - 1);

  ttc_pkg::cor_state_t state, state_next;
  logic signed [35:0]  x, y;
  ttc_pkg::ang_t       z;
  logic                vec;
  logic                neg;
  logic [IW-1:0]       i;
  logic signed [35:0]  xe, ye, abs_x, abs_y, xs, ys;
  logic signed [35:0]  negx, negy;
  ttc_pkg::ang_t       atan_i;
  logic                in_zero, norm_fine, norm_coarse;

  assign xe          = 36'(in_x);
  assign ye          = 36'(in_y);
  assign in_zero     = (in_x == '0) && (in_y == '0);
  assign abs_x       = x[35] ? -x : x;
  assign abs_y       = y[35] ? -y : y;
  assign norm_fine   = (abs_x < ttc_pkg::NORM_LIMIT) && (abs_y < ttc_pkg::NORM_LIMIT);
  assign norm_coarse = (abs_x < ttc_pkg::NORM_COARSE) && (abs_y < ttc_pkg::NORM_COARSE);
  assign xs          = x >>> i;
  assign ys          = y >>> i;
  assign atan_i      = ttc_pkg::atan_entry(ttc_pkg::TAB_IDX_W'(i));
  assign negx        = -x;
  assign negy        = -y;

  always_comb begin
    state_next = state;
    unique case (state)
      ttc_pkg::COR_IDLE: begin
        if (ctl.start) begin
          if (!ctl.vec) begin
            state_next = ttc_pkg::COR_ITER;
          end else if (in_zero) begin
            state_next = ttc_pkg::COR_DONE;
          end else begin
            state_next = ttc_pkg::COR_NORM;
          end
        end
      end
      ttc_pkg::COR_NORM: begin
        if (!norm_fine) begin
          state_next = ttc_pkg::COR_ITER;
        end
      end
      ttc_pkg::COR_ITER: begin
        if (i == LAST) begin
          state_next = ttc_pkg::COR_DONE;
        end
      end
      ttc_pkg::COR_DONE: state_next = ttc_pkg::COR_IDLE;
      default:           state_next = ttc_pkg::COR_IDLE;
    endcase
  end

  always_comb begin
    done  = (state == ttc_pkg::COR_DONE);
    res_x = neg ? negx[31:0] : x[31:0];
    res_y = neg ? negy[31:0] : y[31:0];
    res_z = z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ttc_pkg::COR_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ttc_pkg::COR_IDLE: begin
        i   <= '0;
        vec <= ctl.vec;
        if (ctl.start && ctl.vec) begin
          neg <= 1'b0;
          if (xe < 0) begin
            x <= -xe;
            y <= -ye;
            z <= (ye >= 0) ? ttc_pkg::ANG_HALF : -ttc_pkg::ANG_HALF;
          end else begin
            x <= xe;
            y <= ye;
            z <= '0;
          end
        end else if (ctl.start) begin
          x <= ttc_pkg::COR_K;
          y <= '0;
          // fold angles beyond a quarter turn, negate at the end
          if (in_z > ttc_pkg::ANG_QUARTER) begin
            z   <= in_z - ttc_pkg::ANG_HALF;
            neg <= 1'b1;
          end else if (in_z < -ttc_pkg::ANG_QUARTER) begin
            z   <= in_z + ttc_pkg::ANG_HALF;
            neg <= 1'b1;
          end else begin
            z   <= in_z;
            neg <= 1'b0;
          end
        end
      end
      ttc_pkg::COR_NORM: begin
        if (norm_coarse) begin
          x <= x <<< 4;
          y <= y <<< 4;
        end else if (norm_fine) begin
          x <= x <<< 1;
          y <= y <<< 1;
        end
      end
      ttc_pkg::COR_ITER: begin
        i <= i + 1'b1;
        if (vec ? (y > 0) : (z < 0)) begin
          x <= x + ys;
          y <= y - xs;
          z <= vec ? z + atan_i : z + atan_i;
        end else begin
          x <= x - ys;
          y <= y + xs;
          z <= z - atan_i;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- design/ttc_back.sv -----
// ----------------------------------------------------------------------------
// ttc_back
// Sequencer that turns one smoothed set into roll, pitch and heading using
// the shared CORDIC and one shared multiplier, with a result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ttc_back #(
  parameter int STAGES = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               q_empty,
  input  wire ttc_pkg::ttc_item_t q_item,
  output logic                    q_pop,
  ttc_result_if.source            result
);

  ttc_pkg::bk_state_t state, state_next;
  ttc_pkg::mul_op_t   op;
  ttc_pkg::ttc_item_t it;
  ttc_pkg::ang_t      roll, pitch, head;
  logic signed [31:0] cr, sr, cp, sp;
  logic signed [27:0] den, bot, t1, t2, t3;
  logic signed [15:0] r_out, p_out, h_out, h_wrap;
  logic signed [65:0] acc, sum, r30, r48;
  logic signed [59:0] prod;
  logic signed [27:0] mul_a;
  logic signed [31:0] mul_b;
  logic               clr, sh;
  ttc_pkg::ang_t      ang_sel;
  logic signed [27:0] ang_lo, ang_hi;
  logic               cor_start, cor_state, out_free;
  ttc_pkg::cor_ctl_t  cor_ctl;
  logic signed [27:0] cor_y, cor_x;
  ttc_pkg::ang_t      cor_z, cor_rz;
  logic               cor_done;
  logic signed [31:0] cor_rx, cor_ry;

  ttc_cordic #(.STAGES(STAGES)) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .ctl   (cor_ctl),
    .in_y  (cor_y),
    .in_x  (cor_x),
    .in_z  (cor_z),
    .done  (cor_done),
    .res_x (cor_rx),
    .res_y (cor_ry),
    .res_z (cor_rz)
  );

  assign out_free  = !result.valid || result.ready;
  assign q_pop     = (state == ttc_pkg::BK_IDLE) && !q_empty;
  assign cor_state = (state_next == ttc_pkg::BK_ATAN_ROLL) ||
                     (state_next == ttc_pkg::BK_SC_ROLL) ||
                     (state_next == ttc_pkg::BK_ATAN_PITCH) ||
                     (state_next == ttc_pkg::BK_SC_PITCH) ||
                     (state_next == ttc_pkg::BK_ATAN_HEAD);

  always_comb begin
    state_next = state;
    unique case (state)
      ttc_pkg::BK_IDLE:       if (!q_empty) state_next = ttc_pkg::BK_ATAN_ROLL;
      ttc_pkg::BK_ATAN_ROLL:  if (cor_done) state_next = ttc_pkg::BK_SC_ROLL;
      ttc_pkg::BK_SC_ROLL:    if (cor_done) state_next = ttc_pkg::BK_MUL_A;
      ttc_pkg::BK_MUL_A:      state_next = ttc_pkg::BK_MUL_B;
      ttc_pkg::BK_MUL_B: begin
        if (op == ttc_pkg::OP_DEN1) begin
          state_next = ttc_pkg::BK_ATAN_PITCH;
        end else if (op == ttc_pkg::OP_T3) begin
          state_next = ttc_pkg::BK_ATAN_HEAD;
        end else if (op == ttc_pkg::OP_HD1) begin
          state_next = ttc_pkg::BK_OUT;
        end else begin
          state_next = ttc_pkg::BK_MUL_A;
        end
      end
      ttc_pkg::BK_ATAN_PITCH: if (cor_done) state_next = ttc_pkg::BK_SC_PITCH;
      ttc_pkg::BK_SC_PITCH:   if (cor_done) state_next = ttc_pkg::BK_MUL_A;
      ttc_pkg::BK_ATAN_HEAD:  if (cor_done) state_next = ttc_pkg::BK_MUL_A;
      ttc_pkg::BK_OUT:        if (out_free) state_next = ttc_pkg::BK_IDLE;
      default:                state_next = ttc_pkg::BK_IDLE;
    endcase
  end

  // cordic operands follow the state
  always_comb begin
    cor_ctl.start = cor_start;
    cor_ctl.vec   = 1'b1;
    cor_y         = '0;
    cor_x         = '0;
    cor_z         = '0;
    unique case (state)
      ttc_pkg::BK_ATAN_ROLL: begin
        cor_y = 28'(it.ay);
        cor_x = 28'(it.az);
      end
      ttc_pkg::BK_ATAN_PITCH: begin
        cor_y = -28'(it.ax);
        cor_x = den;
      end
      ttc_pkg::BK_ATAN_HEAD: begin
        cor_y = t1 - t3;
        cor_x = bot;
      end
      ttc_pkg::BK_SC_ROLL: begin
        cor_ctl.vec = 1'b0;
        cor_z       = roll;
      end
      ttc_pkg::BK_SC_PITCH: begin
        cor_ctl.vec = 1'b0;
        cor_z       = pitch;
      end
      default: begin
      end
    endcase
  end

  // multiplier operands; angle scaling is split into low and high partial products
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    clr     = 1'b0;
    sh      = 1'b0;
    ang_sel = roll;
    if (op == ttc_pkg::OP_PT0 || op == ttc_pkg::OP_PT1) begin
      ang_sel = pitch;
    end else if (op == ttc_pkg::OP_HD0 || op == ttc_pkg::OP_HD1) begin
      ang_sel = head;
    end
    ang_lo = $signed({11'b0, ang_sel[16:0]});
    ang_hi = 28'($signed(ang_sel[33:17]));
    unique case (op)
      ttc_pkg::OP_DEN0: begin mul_a = 28'(it.ay); mul_b = sr; clr = 1'b1; end
      ttc_pkg::OP_DEN1: begin mul_a = 28'(it.az); mul_b = cr; end
      ttc_pkg::OP_BOT0: begin mul_a = 28'(it.mz); mul_b = sp; clr = 1'b1; end
      ttc_pkg::OP_BOT1: begin mul_a = 28'(it.mx); mul_b = cp; end
      ttc_pkg::OP_T1:   begin mul_a = 28'(it.my); mul_b = cr; clr = 1'b1; end
      ttc_pkg::OP_T2:   begin mul_a = 28'(it.mz); mul_b = sr; clr = 1'b1; end
      ttc_pkg::OP_T3:   begin mul_a = t2; mul_b = cp; clr = 1'b1; end
      ttc_pkg::OP_RL0, ttc_pkg::OP_PT0, ttc_pkg::OP_HD0: begin
        mul_a = ang_lo;
        mul_b = ttc_pkg::ANGLE_TO_OUT;
        clr   = 1'b1;
      end
      ttc_pkg::OP_RL1, ttc_pkg::OP_PT1, ttc_pkg::OP_HD1: begin
        mul_a = ang_hi;
        mul_b = ttc_pkg::ANGLE_TO_OUT;
        sh    = 1'b1;
      end
      default: begin
      end
    endcase
    sum    = (clr ? 66'sd0 : acc) + (sh ? (66'(prod) <<< 17) : 66'(prod));
    r30    = (sum + 66'sd536870912) >>> 30;
    r48    = (sum + (66'sd1 <<< 47)) >>> 48;
    h_wrap = h_out[15] ? h_out + ttc_pkg::FULL_TURN_OUT : h_out;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ttc_pkg::BK_IDLE;
      cor_start <= 1'b0;
      op        <= ttc_pkg::OP_DEN0;
    end else begin
      state     <= state_next;
      cor_start <= cor_state && (state_next != state);
      if (state == ttc_pkg::BK_IDLE) begin
        op <= ttc_pkg::OP_DEN0;
      end else if (state == ttc_pkg::BK_MUL_B) begin
        op <= ttc_pkg::mul_op_t'(op + 4'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      it <= q_item;
    end
    if (cor_done) begin
      case (state)
        ttc_pkg::BK_ATAN_ROLL:  roll  <= cor_rz;
        ttc_pkg::BK_ATAN_PITCH: pitch <= cor_rz;
        ttc_pkg::BK_ATAN_HEAD:  head  <= cor_rz;
        ttc_pkg::BK_SC_ROLL: begin
          cr <= cor_rx;
          sr <= cor_ry;
        end
        ttc_pkg::BK_SC_PITCH: begin
          cp <= cor_rx;
          sp <= cor_ry;
        end
        default: begin
        end
      endcase
    end
    if (state == ttc_pkg::BK_MUL_A) begin
      prod <= 60'(mul_a) * 60'(mul_b);
    end
    if (state == ttc_pkg::BK_MUL_B) begin
      acc <= sum;
      case (op)
        ttc_pkg::OP_DEN1: den   <= r30[27:0];
        ttc_pkg::OP_BOT1: bot   <= r30[27:0];
        ttc_pkg::OP_T1:   t1    <= r30[27:0];
        ttc_pkg::OP_T2:   t2    <= r30[27:0];
        ttc_pkg::OP_T3:   t3    <= r30[27:0];
        ttc_pkg::OP_RL1:  r_out <= r48[15:0];
        ttc_pkg::OP_PT1:  p_out <= r48[15:0];
        ttc_pkg::OP_HD1:  h_out <= r48[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (state == ttc_pkg::BK_OUT && out_free) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ttc_pkg::BK_OUT && out_free) begin
      result.roll_angle    <= r_out[14:0];
      result.pitch_angle   <= p_out[14:0];
      result.heading_angle <= h_wrap[14:0];
    end
  end

endmodule

`default_nettype wire

// ----- design/tilt_compensated_compass.sv -----
// ----------------------------------------------------------------------------
// tilt_compensated_compass
// Smoothed roll, pitch and tilt-compensated heading from raw sensor sets.
// ----------------------------------------------------------------------------
// Sequencing: roll, pitch and heading are worked out in turn by the shared
//   iterative CORDIC (one micro-rotation per cycle), with a normalizing pre-shift
//   ahead of the arctangents, and by the shared multiplier, which registers its product.
// Flow: a two-entry queue lets the front take new sets while the back is busy.
// Reset: clears averages, queue and sequencer; registers go to their defaults.
`default_nettype none

module tilt_compensated_compass #(
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  ttc_sample_if.sink       sample,
  ttc_result_if.source     result
);

  ttc_pkg::cfg_t      cfg;
  ttc_pkg::reg_idx_t  idx;
  logic               wr;
  logic               q_push, q_pop, q_full, q_empty;
  ttc_pkg::ttc_item_t q_in, q_head;

  assign pready = 1'b1;
  assign idx    = ttc_pkg::reg_idx_t'(paddr[3:2]);
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain  <= ttc_pkg::GAIN_RESET;
      cfg.off_x <= '0;
      cfg.off_y <= '0;
      cfg.off_z <= '0;
    end else if (wr) begin
      unique case (idx)
        ttc_pkg::REG_GAIN:  cfg.gain  <= pwdata[8:0];
        ttc_pkg::REG_OFF_X: cfg.off_x <= pwdata[15:0];
        ttc_pkg::REG_OFF_Y: cfg.off_y <= pwdata[15:0];
        ttc_pkg::REG_OFF_Z: cfg.off_z <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ttc_pkg::REG_GAIN:  prdata = {23'b0, cfg.gain};
      ttc_pkg::REG_OFF_X: prdata = 32'(cfg.off_x);
      ttc_pkg::REG_OFF_Y: prdata = 32'(cfg.off_y);
      ttc_pkg::REG_OFF_Z: prdata = 32'(cfg.off_z);
      default:            prdata = '0;
    endcase
  end

  ttc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .sample    (sample),
    .q_full    (q_full),
    .push      (q_push),
    .push_item (q_in)
  );

  ttc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head_item (q_head)
  );

  ttc_back #(.STAGES(CORDIC_STAGES)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_item  (q_head),
    .q_pop   (q_pop),
    .result  (result)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("queue pop while empty");

  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.heading_angle < 15'd23040))
    else $error("heading out of range");

endmodule

`default_nettype wire
